@@ hdl/ac_line_frequency_monitor_top_assert.svh @@
// ----------------------------------------------------------------------------
// AC line frequency monitor assertion macros
// Concurrent assertion wrappers, compiled out when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef AC_LINE_FREQUENCY_MONITOR_TOP_ASSERT_SVH
`define AC_LINE_FREQUENCY_MONITOR_TOP_ASSERT_SVH

`ifndef SYNTH

// same-cycle implication
`define ACFM_ASSERT_IMP(lbl, clk_s, rstn_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!(rstn_s)) (ante) |-> (cons)) \
    else $error("acfm assertion failed");

// next-cycle implication
`define ACFM_ASSERT_NXT(lbl, clk_s, rstn_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!(rstn_s)) (ante) |=> (cons)) \
    else $error("acfm assertion failed");

`else

`define ACFM_ASSERT_IMP(lbl, clk_s, rstn_s, ante, cons)
`define ACFM_ASSERT_NXT(lbl, clk_s, rstn_s, ante, cons)

`endif

`endif

@@ hdl/acfm_pkg.sv @@
// ----------------------------------------------------------------------------
// acfm_pkg
// Shared types and constants of the AC line frequency monitor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package acfm_pkg;

  localparam int unsigned CntW  = 16;
  localparam int unsigned BadW  = 8;
  localparam int unsigned DataW = 32;
  localparam int unsigned AddrW = 5;
  localparam int unsigned IdxW  = 3;

  localparam logic [CntW-1:0] CNT_MAX = {CntW{1'b1}};
  localparam logic [BadW-1:0] BAD_MAX = {BadW{1'b1}};

  // register indexes
  localparam logic [IdxW-1:0] REG_WINDOW_TICKS   = 3'd0;
  localparam logic [IdxW-1:0] REG_MIN_TOGGLES    = 3'd1;
  localparam logic [IdxW-1:0] REG_MAX_TOGGLES    = 3'd2;
  localparam logic [IdxW-1:0] REG_PERSIST_LIMIT  = 3'd3;
  localparam logic [IdxW-1:0] REG_EXPECTED_TICKS = 3'd4;
  localparam logic [IdxW-1:0] REG_TICK_TOLERANCE = 3'd5;

  // reset values
  localparam logic [CntW-1:0] RST_WINDOW_TICKS   = 16'd1000;
  localparam logic [CntW-1:0] RST_MIN_TOGGLES    = 16'd90;
  localparam logic [CntW-1:0] RST_MAX_TOGGLES    = 16'd130;
  localparam logic [BadW-1:0] RST_PERSIST_LIMIT  = 8'd12;
  localparam logic [CntW-1:0] RST_EXPECTED_TICKS = 16'd1000;
  localparam logic [CntW-1:0] RST_TICK_TOLERANCE = 16'd10;

  // item opcodes
  localparam logic OP_TICK    = 1'b0;
  localparam logic OP_MONITOR = 1'b1;

  typedef struct packed {
    logic [CntW-1:0] window_ticks;
    logic [CntW-1:0] min_toggles;
    logic [CntW-1:0] max_toggles;
    logic [BadW-1:0] persist_limit;
    logic [CntW-1:0] expected_ticks;
    logic [CntW-1:0] tick_tolerance;
  } acfm_cfg_t;

  typedef struct packed {
    logic op;
    logic line_level;
    logic skip_check;
  } acfm_item_t;

  typedef struct packed {
    logic after_cross;
    logic window_end;
    logic freq_error;
    logic freq_fault_clear;
    logic tick_fault;
  } acfm_res_t;

endpackage

`default_nettype wire

@@ hdl/ac_line_frequency_monitor_top.sv @@
// ----------------------------------------------------------------------------
// ac_line_frequency_monitor_top
// AC line frequency window monitor: tick/monitor items in, one result out.
// ----------------------------------------------------------------------------
//  channel  | ports                                        | role
//  ---------+----------------------------------------------+--------------
//  in       | in_valid, in_stall, in_op, in_line_level,    | item input
//           | in_skip_check                                |
//  out      | out_valid, out_stall, out_after_cross, ...   | one result/item
//  cfg      | psel, penable, pwrite, paddr, pwdata, prdata | APB registers
//
//  One item per cycle unless out_stall holds the result; an item passes the
//  input register and the result register, set by the single update pass.
//  Synchronous active-low reset clears the state and the valid flags;
//  registers return to their defaults with no clearing pass.
//  A stalled result holds the result register; the input register then
//  holds one more item and in_stall rises until the result transfer happens.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "ac_line_frequency_monitor_top_assert.svh"

module ac_line_frequency_monitor_top (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire logic                       in_op,
  input  wire logic                       in_line_level,
  input  wire logic                       in_skip_check,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output logic                            out_after_cross,
  output logic                            out_window_end,
  output logic                            out_freq_error,
  output logic                            out_freq_fault_clear,
  output logic                            out_tick_fault,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [acfm_pkg::AddrW-1:0] paddr,
  input  wire logic [acfm_pkg::DataW-1:0] pwdata,
  output logic      [acfm_pkg::DataW-1:0] prdata,
  output logic                            pready
);
  import acfm_pkg::*;

  acfm_cfg_t  cfg;
  acfm_item_t item_r;
  logic       item_valid_r;
  logic       core_ready;
  acfm_res_t  res;

  assign in_stall = item_valid_r && !core_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
    end else if (!in_stall) begin
      item_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      item_r <= '{op: in_op, line_level: in_line_level, skip_check: in_skip_check};
    end
  end

  acfm_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  acfm_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .item_valid (item_valid_r),
    .item       (item_r),
    .ready      (core_ready),
    .res_valid  (out_valid),
    .res        (res),
    .res_stall  (out_stall)
  );

  assign out_after_cross      = res.after_cross;
  assign out_window_end       = res.window_end;
  assign out_freq_error       = res.freq_error;
  assign out_freq_fault_clear = res.freq_fault_clear;
  assign out_tick_fault       = res.tick_fault;

  // input side only backs up behind a held result
  `ACFM_ASSERT_IMP(a_stall_cause, clk, rst_n, in_stall,
                   item_valid_r && out_valid && out_stall)
  // a staged item always lands in the result register
  `ACFM_ASSERT_NXT(a_stage_to_out, clk, rst_n, item_valid_r && !in_stall, out_valid)
  // tick fault only from a monitor event, which never touches window fields
  `ACFM_ASSERT_IMP(a_tick_fault_excl, clk, rst_n, out_valid && out_tick_fault,
                   !out_after_cross && !out_window_end && !out_freq_fault_clear)
  // a fault clear comes with a window close and a cleared flag
  `ACFM_ASSERT_IMP(a_clear_consistent, clk, rst_n, out_valid && out_freq_fault_clear,
                   out_window_end && !out_freq_error)

endmodule

`default_nettype wire

@@ hdl/acfm_regs.sv @@
// ----------------------------------------------------------------------------
// acfm_regs
// APB-style configuration registers of the AC line frequency monitor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module acfm_regs (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      psel,
  input  wire logic                      penable,
  input  wire logic                      pwrite,
  input  wire logic [acfm_pkg::AddrW-1:0] paddr,
  input  wire logic [acfm_pkg::DataW-1:0] pwdata,
  output logic      [acfm_pkg::DataW-1:0] prdata,
  output logic                           pready,
  output acfm_pkg::acfm_cfg_t            cfg
);
  import acfm_pkg::*;

  acfm_cfg_t       cfg_r;
  acfm_cfg_t       cfg_nxt;
  logic [IdxW-1:0] idx;
  logic            wr_en;

  assign idx    = paddr[AddrW-1:2];
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (idx)
        REG_WINDOW_TICKS:   cfg_nxt.window_ticks   = pwdata[CntW-1:0];
        REG_MIN_TOGGLES:    cfg_nxt.min_toggles    = pwdata[CntW-1:0];
        REG_MAX_TOGGLES:    cfg_nxt.max_toggles    = pwdata[CntW-1:0];
        REG_PERSIST_LIMIT:  cfg_nxt.persist_limit  = pwdata[BadW-1:0];
        REG_EXPECTED_TICKS: cfg_nxt.expected_ticks = pwdata[CntW-1:0];
        REG_TICK_TOLERANCE: cfg_nxt.tick_tolerance = pwdata[CntW-1:0];
        default:            cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.window_ticks   <= RST_WINDOW_TICKS;
      cfg_r.min_toggles    <= RST_MIN_TOGGLES;
      cfg_r.max_toggles    <= RST_MAX_TOGGLES;
      cfg_r.persist_limit  <= RST_PERSIST_LIMIT;
      cfg_r.expected_ticks <= RST_EXPECTED_TICKS;
      cfg_r.tick_tolerance <= RST_TICK_TOLERANCE;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  always_comb begin
    unique case (idx)
      REG_WINDOW_TICKS:   prdata = {{(DataW-CntW){1'b0}}, cfg_r.window_ticks};
      REG_MIN_TOGGLES:    prdata = {{(DataW-CntW){1'b0}}, cfg_r.min_toggles};
      REG_MAX_TOGGLES:    prdata = {{(DataW-CntW){1'b0}}, cfg_r.max_toggles};
      REG_PERSIST_LIMIT:  prdata = {{(DataW-BadW){1'b0}}, cfg_r.persist_limit};
      REG_EXPECTED_TICKS: prdata = {{(DataW-CntW){1'b0}}, cfg_r.expected_ticks};
      REG_TICK_TOLERANCE: prdata = {{(DataW-CntW){1'b0}}, cfg_r.tick_tolerance};
      default:            prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

@@ hdl/acfm_core.sv @@
// ----------------------------------------------------------------------------
// acfm_core
// Monitor state, per-item update logic and the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module acfm_core (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire acfm_pkg::acfm_cfg_t  cfg,
  input  wire logic                 item_valid,
  input  wire acfm_pkg::acfm_item_t item,
  output logic                      ready,
  output logic                      res_valid,
  output acfm_pkg::acfm_res_t       res,
  input  wire logic                 res_stall
);
  import acfm_pkg::*;

  logic            last_level_r, last_level_nxt;
  logic            blank_r, blank_nxt;
  logic [CntW-1:0] toggle_r, toggle_nxt;
  logic [CntW-1:0] window_r, window_nxt;
  logic [BadW-1:0] bad_r, bad_nxt;
  logic            err_r, err_nxt;
  logic [CntW-1:0] tick_r, tick_nxt;
  logic            res_valid_r;
  acfm_res_t       res_r, res_nxt;

  logic [CntW-1:0] toggle_inc;
  logic [CntW-1:0] window_inc;
  logic [BadW-1:0] bad_inc;
  logic            bad_win;
  logic [CntW:0]   tick_plus_tol;
  logic [CntW:0]   exp_plus_tol;
  logic            take;

  assign ready     = !res_valid_r || !res_stall;
  assign take      = item_valid && ready;
  assign res_valid = res_valid_r;
  assign res       = res_r;

  assign tick_plus_tol = {1'b0, tick_r} + {1'b0, cfg.tick_tolerance};
  assign exp_plus_tol  = {1'b0, cfg.expected_ticks} + {1'b0, cfg.tick_tolerance};
  assign window_inc    = (window_r != CNT_MAX) ? window_r + 1'b1 : window_r;

  always_comb begin
    last_level_nxt = last_level_r;
    blank_nxt      = blank_r;
    toggle_nxt     = toggle_r;
    window_nxt     = window_r;
    bad_nxt        = bad_r;
    err_nxt        = err_r;
    tick_nxt       = tick_r;
    res_nxt        = '0;
    toggle_inc     = toggle_r;
    bad_inc        = (bad_r != BAD_MAX) ? bad_r + 1'b1 : bad_r;
    bad_win        = 1'b0;

    unique case (item.op)
      OP_TICK: begin
        // one blanked tick after each detected change
        if (blank_r) begin
          blank_nxt           = 1'b0;
          res_nxt.after_cross = 1'b1;
        end else if (item.line_level != last_level_r) begin
          last_level_nxt = item.line_level;
          blank_nxt      = 1'b1;
          if (toggle_r != CNT_MAX) begin
            toggle_inc = toggle_r + 1'b1;
          end
        end
        toggle_nxt = toggle_inc;
        window_nxt = window_inc;

        if (window_inc >= cfg.window_ticks) begin
          res_nxt.window_end = 1'b1;
          bad_win = (toggle_inc < cfg.min_toggles) || (toggle_inc > cfg.max_toggles);
          if (bad_win) begin
            bad_nxt = bad_inc;
            if (bad_inc > cfg.persist_limit) begin
              err_nxt = 1'b1;
            end
          end else begin
            res_nxt.freq_fault_clear = 1'b1;
            err_nxt = 1'b0;
            bad_nxt = '0;
          end
          window_nxt = '0;
          toggle_nxt = '0;
        end

        if (tick_r != CNT_MAX) begin
          tick_nxt = tick_r + 1'b1;
        end
      end
      OP_MONITOR: begin
        // lower bound below zero never trips: compare tick + tol against expected
        if (!item.skip_check) begin
          res_nxt.tick_fault = (tick_plus_tol < {1'b0, cfg.expected_ticks}) ||
                               ({1'b0, tick_r} > exp_plus_tol);
        end
        tick_nxt = '0;
      end
      default: ;
    endcase

    res_nxt.freq_error = err_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_level_r <= 1'b0;
      blank_r      <= 1'b0;
      toggle_r     <= '0;
      window_r     <= '0;
      bad_r        <= '0;
      err_r        <= 1'b0;
      tick_r       <= '0;
      res_valid_r  <= 1'b0;
    end else begin
      if (take) begin
        last_level_r <= last_level_nxt;
        blank_r      <= blank_nxt;
        toggle_r     <= toggle_nxt;
        window_r     <= window_nxt;
        bad_r        <= bad_nxt;
        err_r        <= err_nxt;
        tick_r       <= tick_nxt;
      end
      if (ready) begin
        res_valid_r <= item_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      res_r <= res_nxt;
    end
  end

endmodule

`default_nettype wire

@@ verif/ac_line_frequency_monitor_tb.sv @@
// ----------------------------------------------------------------------------
// ac_line_frequency_monitor_top testbench
// Drives tick and monitor items with random gaps and result-side stalls.
// Every transfer is checked against an in-bench model of the window, blanking,
// bad-window persistence and tick-count logic. Directed tests cover the
// register extremes and the corner cases. Random phases run mains-like line
// patterns under varied settings.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import acfm_pkg::*;

  localparam int unsigned LimitCycles = 1_000_000;

  logic             clk;
  logic             rst_n         = 1'b0;
  logic             in_valid      = 1'b0;
  logic             in_stall;
  logic             in_op         = OP_TICK;
  logic             in_line_level = 1'b0;
  logic             in_skip_check = 1'b0;
  logic             out_valid;
  logic             out_stall     = 1'b0;
  logic             out_after_cross;
  logic             out_window_end;
  logic             out_freq_error;
  logic             out_freq_fault_clear;
  logic             out_tick_fault;
  logic             psel          = 1'b0;
  logic             penable       = 1'b0;
  logic             pwrite        = 1'b0;
  logic [AddrW-1:0] paddr         = '0;
  logic [DataW-1:0] pwdata        = '0;
  logic [DataW-1:0] prdata;
  logic             pready;

  // model state
  acfm_cfg_t       cfg_shadow;
  logic            line_prev;
  logic            blanking;
  logic [CntW-1:0] cross_count;
  logic [CntW-1:0] window_pos;
  logic [BadW-1:0] bad_run;
  logic            freq_err_flag;
  logic [CntW-1:0] tick_total;

  acfm_res_t status_due[$];
  int        fail_count  = 0;
  int        in_wait_max  = 12;
  int        out_wait_max = 12;
  int        hold_cycles  = 0;

  ac_line_frequency_monitor_top i_dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_op                (in_op),
    .in_line_level        (in_line_level),
    .in_skip_check        (in_skip_check),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_after_cross      (out_after_cross),
    .out_window_end       (out_window_end),
    .out_freq_error       (out_freq_error),
    .out_freq_fault_clear (out_freq_fault_clear),
    .out_tick_fault       (out_tick_fault),
    .psel                 (psel),
    .penable              (penable),
    .pwrite               (pwrite),
    .paddr                (paddr),
    .pwdata               (pwdata),
    .prdata               (prdata),
    .pready               (pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #(LimitCycles * 10);
    $display("Test completed with failures");
    $finish;
  end

  function automatic int draw_wait(int max_wait);
    return (max_wait == 0) ? 0 : int'($urandom_range(0, max_wait));
  endfunction

  function automatic acfm_res_t predict_status(acfm_item_t it);
    acfm_res_t r;
    int        lo;
    int        hi;
    r = '0;
    if (it.op == OP_TICK) begin
      if (blanking) begin
        blanking = 1'b0;
        r.after_cross = 1'b1;
      end else if (it.line_level != line_prev) begin
        line_prev = it.line_level;
        blanking  = 1'b1;
        if (cross_count != CNT_MAX) cross_count = cross_count + 1'b1;
      end
      if (window_pos != CNT_MAX) window_pos = window_pos + 1'b1;
      if (window_pos >= cfg_shadow.window_ticks) begin
        r.window_end = 1'b1;
        if (cross_count < cfg_shadow.min_toggles || cross_count > cfg_shadow.max_toggles) begin
          if (bad_run != BAD_MAX) bad_run = bad_run + 1'b1;
          if (bad_run > cfg_shadow.persist_limit) freq_err_flag = 1'b1;
        end else begin
          r.freq_fault_clear = 1'b1;
          freq_err_flag      = 1'b0;
          bad_run            = '0;
        end
        // a crossing seen on the closing tick counts toward the closing window
        window_pos  = '0;
        cross_count = '0;
      end
      if (tick_total != CNT_MAX) tick_total = tick_total + 1'b1;
    end else begin
      if (!it.skip_check) begin
        lo = int'(cfg_shadow.expected_ticks) - int'(cfg_shadow.tick_tolerance);
        hi = int'(cfg_shadow.expected_ticks) + int'(cfg_shadow.tick_tolerance);
        if (int'(tick_total) < lo || int'(tick_total) > hi) r.tick_fault = 1'b1;
      end
      tick_total = '0;
    end
    r.freq_error = freq_err_flag;
    return r;
  endfunction

  // one transfer on the input channel; the status is predicted on acceptance
  task automatic apply_item(input logic op_i, input logic level_i, input logic skip_i);
    acfm_item_t it;
    int         gap;
    it  = '{op: op_i, line_level: level_i, skip_check: skip_i};
    gap = draw_wait(in_wait_max);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_op         <= op_i;
    in_line_level <= level_i;
    in_skip_check <= skip_i;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    status_due.push_back(predict_status(it));
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (status_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [IdxW-1:0] idx, input logic [DataW-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    case (idx)
      REG_WINDOW_TICKS:   cfg_shadow.window_ticks   = value[CntW-1:0];
      REG_MIN_TOGGLES:    cfg_shadow.min_toggles    = value[CntW-1:0];
      REG_MAX_TOGGLES:    cfg_shadow.max_toggles    = value[CntW-1:0];
      REG_PERSIST_LIMIT:  cfg_shadow.persist_limit  = value[BadW-1:0];
      REG_EXPECTED_TICKS: cfg_shadow.expected_ticks = value[CntW-1:0];
      REG_TICK_TOLERANCE: cfg_shadow.tick_tolerance = value[CntW-1:0];
      default: ;
    endcase
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic apply_cfg(input acfm_cfg_t c);
    write_reg(REG_WINDOW_TICKS,   DataW'(c.window_ticks));
    write_reg(REG_MIN_TOGGLES,    DataW'(c.min_toggles));
    write_reg(REG_MAX_TOGGLES,    DataW'(c.max_toggles));
    write_reg(REG_PERSIST_LIMIT,  DataW'(c.persist_limit));
    write_reg(REG_EXPECTED_TICKS, DataW'(c.expected_ticks));
    write_reg(REG_TICK_TOLERANCE, DataW'(c.tick_tolerance));
  endtask

  task automatic check_bit(input string name, input logic exp_v, input logic act_v);
    if (act_v !== exp_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin : status_check
    acfm_res_t exp_r;
    if (rst_n && out_valid && !out_stall) begin
      if (status_due.size() == 0) begin
        $error("result transfer with nothing pending");
        fail_count++;
      end else begin
        exp_r = status_due.pop_front();
        check_bit("after_cross",      exp_r.after_cross,      out_after_cross);
        check_bit("window_end",       exp_r.window_end,       out_window_end);
        check_bit("freq_error",       exp_r.freq_error,       out_freq_error);
        check_bit("freq_fault_clear", exp_r.freq_fault_clear, out_freq_fault_clear);
        check_bit("tick_fault",       exp_r.tick_fault,       out_tick_fault);
      end
    end
  end

  // result side: per-transfer stall, or one long hold-off when requested
  initial begin : receiver
    int w;
    @(posedge clk);
    forever begin
      w = draw_wait(out_wait_max);
      if (hold_cycles > 0) begin
        w           = hold_cycles;
        hold_cycles = 0;
      end
      if (w > 0) begin
        out_stall <= 1'b1;
        repeat (w) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  // reset settings, roughly 50 Hz line: about 100 crossings per 1000 ticks
  task automatic test_default_window();
    int   i;
    int   run;
    int   half;
    logic lvl;
    lvl  = 1'b0;
    run  = 0;
    half = 10;
    for (i = 0; i < 1000; i++) begin
      run++;
      if (run >= half) begin
        lvl  = ~lvl;
        run  = 0;
        half = $urandom_range(9, 11);
      end
      apply_item(OP_TICK, lvl, 1'($urandom_range(0, 1)));
    end
    apply_item(OP_MONITOR, 1'b0, 1'b0);
    apply_item(OP_MONITOR, 1'b1, 1'b1);
    drain();
  endtask

  // good, bad, bad (raises error), good (clears) windows of four ticks
  task automatic test_directed_windows();
    acfm_cfg_t       c;
    logic [15:0]     pattern;
    int              i;
    pattern = 16'b0110_0000_0000_1101;
    c = '{window_ticks: 16'd4, min_toggles: 16'd1, max_toggles: 16'd2,
          persist_limit: 8'd1, expected_ticks: 16'd6, tick_tolerance: 16'd1};
    apply_cfg(c);
    for (i = 0; i < 16; i++) apply_item(OP_TICK, pattern[15-i], 1'b0);
    apply_item(OP_MONITOR, 1'b0, 1'b0);
    apply_item(OP_MONITOR, 1'b1, 1'b1);
    drain();
  endtask

  task automatic test_zero_window();
    int i;
    write_reg(REG_WINDOW_TICKS, '0);
    write_reg(REG_PERSIST_LIMIT, '0);
    for (i = 0; i < 8; i++) apply_item(OP_TICK, 1'($urandom_range(0, 1)), 1'b0);
    drain();
  endtask

  task automatic test_window_shortened();
    int i;
    write_reg(REG_WINDOW_TICKS, 32'd20);
    for (i = 0; i < 8; i++) apply_item(OP_TICK, i[1], 1'b0);
    drain();
    // position is already past the new length: next tick must close
    write_reg(REG_WINDOW_TICKS, 32'd5);
    for (i = 0; i < 7; i++) apply_item(OP_TICK, i[0], 1'b1);
    drain();
  endtask

  task automatic test_tolerance_bounds();
    int i;
    write_reg(REG_EXPECTED_TICKS, 32'd3);
    write_reg(REG_TICK_TOLERANCE, 32'd10);
    apply_item(OP_MONITOR, 1'b0, 1'b0);
    for (i = 0; i < 13; i++) apply_item(OP_TICK, 1'b0, 1'b0);
    apply_item(OP_MONITOR, 1'b0, 1'b0);
    for (i = 0; i < 14; i++) apply_item(OP_TICK, 1'b1, 1'b0);
    apply_item(OP_MONITOR, 1'b1, 1'b0);
    drain();
    write_reg(REG_EXPECTED_TICKS, DataW'(CNT_MAX));
    write_reg(REG_TICK_TOLERANCE, DataW'(CNT_MAX));
    apply_item(OP_MONITOR, 1'b0, 1'b0);
    drain();
    write_reg(REG_EXPECTED_TICKS, '0);
    write_reg(REG_TICK_TOLERANCE, '0);
    apply_item(OP_MONITOR, 1'b0, 1'b0);
    apply_item(OP_TICK, 1'b0, 1'b0);
    apply_item(OP_MONITOR, 1'b1, 1'b0);
    drain();
  endtask

  // one-tick windows that are all bad: the bad-window count must saturate
  task automatic test_bad_window_saturation();
    int i;
    in_wait_max  = 0;
    out_wait_max = 0;
    write_reg(REG_WINDOW_TICKS, 32'd1);
    write_reg(REG_MIN_TOGGLES, DataW'(CNT_MAX));
    write_reg(REG_MAX_TOGGLES, '0);
    write_reg(REG_PERSIST_LIMIT, DataW'(BAD_MAX));
    for (i = 0; i < 260; i++) apply_item(OP_TICK, 1'($urandom_range(0, 1)), 1'b0);
    drain();
    write_reg(REG_PERSIST_LIMIT, DataW'(BAD_MAX - 1'b1));
    apply_item(OP_TICK, 1'b0, 1'b0);
    drain();
    write_reg(REG_MIN_TOGGLES, '0);
    write_reg(REG_MAX_TOGGLES, DataW'(CNT_MAX));
    apply_item(OP_TICK, 1'b1, 1'b0);
    drain();
  endtask

  task automatic test_backpressure();
    int i;
    in_wait_max  = 0;
    out_wait_max = 12;
    hold_cycles  = 300;
    for (i = 0; i < 40; i++) begin
      apply_item(OP_TICK, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    end
    drain();
    in_wait_max = 12;
    for (i = 0; i < 10; i++) apply_item(OP_TICK, i[0], 1'b0);
    drain();
  endtask

  function automatic int next_monitor_gap(acfm_cfg_t c);
    int spread;
    int t;
    spread = (c.tick_tolerance > 8) ? 8 : int'(c.tick_tolerance);
    t = int'(c.expected_ticks) - spread - 2 + int'($urandom_range(0, 2 * spread + 4));
    if (t < 0) t = 0;
    if (t > 200) t = 200;
    return t;
  endfunction

  task automatic test_random_traffic();
    acfm_cfg_t c;
    int        phase;
    int        n;
    int        r;
    int        half;
    int        run;
    int        since_mon;
    int        target;
    logic      lvl;
    for (phase = 0; phase < 10; phase++) begin
      c.window_ticks   = 16'($urandom_range(1, 24));
      c.min_toggles    = 16'($urandom_range(0, 6));
      c.max_toggles    = c.min_toggles + 16'($urandom_range(0, 6));
      c.persist_limit  = 8'($urandom_range(0, 3));
      c.expected_ticks = 16'($urandom_range(0, 40));
      c.tick_tolerance = 16'($urandom_range(0, 4));
      case (phase)
        0: begin
          c.min_toggles    = '0;
          c.max_toggles    = CNT_MAX;
          c.persist_limit  = BAD_MAX;
          c.tick_tolerance = CNT_MAX;
        end
        1: begin
          c.min_toggles    = CNT_MAX;
          c.max_toggles    = '0;
          c.expected_ticks = CNT_MAX;
          c.tick_tolerance = '0;
        end
        2: c.window_ticks = CNT_MAX;
        3: begin
          c.expected_ticks = '0;
          c.persist_limit  = '0;
        end
        default: ;
      endcase
      in_wait_max  = (phase % 3 == 0) ? 0 : 12;
      out_wait_max = (phase % 4 == 1) ? 0 : 12;
      apply_cfg(c);
      half      = $urandom_range(1, 4);
      run       = 0;
      lvl       = 1'($urandom_range(0, 1));
      since_mon = 0;
      target    = next_monitor_gap(c);
      for (n = 0; n < 20; n++) begin
        r = $urandom_range(0, 99);
        if (since_mon >= target || r < 2) begin
          apply_item(OP_MONITOR, 1'($urandom_range(0, 1)), ($urandom_range(0, 3) == 0));
          since_mon = 0;
          target    = next_monitor_gap(c);
        end else begin
          run++;
          if (run >= half) begin
            lvl = ~lvl;
            run = 0;
          end
          // occasional glitch on the line
          apply_item(OP_TICK, (r >= 95) ? 1'($urandom_range(0, 1)) : lvl,
                     1'($urandom_range(0, 1)));
          since_mon++;
        end
      end
      drain();
    end
  endtask

  initial begin : main
    cfg_shadow = '{window_ticks: RST_WINDOW_TICKS, min_toggles: RST_MIN_TOGGLES,
                   max_toggles: RST_MAX_TOGGLES, persist_limit: RST_PERSIST_LIMIT,
                   expected_ticks: RST_EXPECTED_TICKS, tick_tolerance: RST_TICK_TOLERANCE};
    line_prev     = 1'b0;
    blanking      = 1'b0;
    cross_count   = '0;
    window_pos    = '0;
    bad_run       = '0;
    freq_err_flag = 1'b0;
    tick_total    = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    test_default_window();
    test_directed_windows();
    test_zero_window();
    test_window_shortened();
    test_tolerance_bounds();
    test_bad_window_saturation();
    test_backpressure();
    test_random_traffic();

    drain();
    if (fail_count == 0 && status_due.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
